@@ hdl/akla_pkg.sv @@
// Package for the accelerated knob level adjuster: codes, register indexes,
// widths, timing thresholds and the shared hold-off request type.
// No dependencies.
package akla_pkg;

  localparam int ACTION_W = 2;
  localparam int KNOB_W   = 2;
  localparam int CENTRE_W = 12;
  localparam int STEP_W   = 8;
  localparam int SRC_W    = 2;
  localparam int HOLD_W   = 16;
  localparam int TIME_W   = 32;
  localparam int MULT_W   = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CH_W     = 2;
  localparam int SLOT_W   = 3;
  localparam int NUM_CH   = 3;
  localparam int NUM_SLOT = 6;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DETENT   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RECENTRE = 2'd2;

  // knob codes
  localparam logic [KNOB_W-1:0] KNOB_OFS_A = 2'd0;
  localparam logic [KNOB_W-1:0] KNOB_OFS_B = 2'd1;
  localparam logic [KNOB_W-1:0] KNOB_TRIG  = 2'd2;
  localparam logic [KNOB_W-1:0] KNOB_NONE  = 2'd3;

  // trigger source codes
  localparam logic [SRC_W-1:0] SRC_EXT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 2'd3;

  // register reset values
  localparam logic [CENTRE_W-1:0] CENTRE_RESET  = 12'd2048;
  localparam logic [STEP_W-1:0]   STEP_RESET    = 8'd4;
  localparam logic [SRC_W-1:0]    SOURCE_RESET  = 2'd0;
  localparam logic [HOLD_W-1:0]   HOLDOFF_RESET = 16'd500;

  // acceleration thresholds in ms
  localparam logic [TIME_W-1:0] SLOW_MS   = 32'd75;
  localparam logic [TIME_W-1:0] MEDIUM_MS = 32'd50;
  localparam logic [TIME_W-1:0] FAST_MS   = 32'd25;

  localparam logic [MULT_W-1:0] MULT_1 = 3'd1;
  localparam logic [MULT_W-1:0] MULT_2 = 3'd2;
  localparam logic [MULT_W-1:0] MULT_3 = 3'd3;
  localparam logic [MULT_W-1:0] MULT_4 = 3'd4;

  typedef struct packed {
    logic            check;      // detent being committed this cycle
    logic [CH_W-1:0] ch;         // hold-off channel
    logic            at_centre;  // move lands on the centre
  } holdoff_req_t;

endpackage

@@ hdl/akla_if.sv @@
// Channel interfaces for the knob level adjuster: input word and result word.
// Depends on akla_pkg.
interface akla_in_if
  import akla_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KNOB_W-1:0]   knob;
  logic                direction;

  modport source (output valid, action, knob, direction, input ready);
  modport sink   (input valid, action, knob, direction, output ready);
endinterface

interface akla_out_if
  import akla_pkg::*;
#(
  parameter int LEVEL_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [KNOB_W-1:0]     knob_id;
  logic [LEVEL_BITS-1:0] level;
  logic                  applied;
  logic [MULT_W-1:0]     multiplier;

  modport source (output valid, knob_id, level, applied, multiplier, input ready);
  modport sink   (input valid, knob_id, level, applied, multiplier, output ready);
endinterface

@@ hdl/akla_accel.sv @@
// Millisecond counter, per knob/direction detent timestamps and the
// acceleration multiplier. Depends on akla_pkg.
module akla_accel
  import akla_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              take,
  input  logic [SLOT_W-1:0] slot,
  output logic [TIME_W-1:0] now,
  output logic [MULT_W-1:0] mult
);

  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] last_detent [NUM_SLOT];
  logic [TIME_W-1:0] since;

  assign now   = now_ms;
  assign since = now_ms - last_detent[slot];

  always_comb begin
    priority if (since > SLOW_MS) begin
      mult = MULT_1;
    end else if (since > MEDIUM_MS) begin
      mult = MULT_2;
    end else if (since > FAST_MS) begin
      mult = MULT_3;
    end else begin
      mult = MULT_4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= '0;
      for (int i = 0; i < NUM_SLOT; i++) begin
        last_detent[i] <= '0;
      end
    end else begin
      if (tick) begin
        now_ms <= now_ms + TIME_W'(1);
      end
      if (take) begin
        last_detent[slot] <= now_ms;
      end
    end
  end

endmodule

@@ hdl/akla_holdoff.sv @@
// Per-channel hold-off after a level lands on the centre; shared by the
// offset and trigger level of a channel, where both exist. Depends on akla_pkg.
module akla_holdoff
  import akla_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  holdoff_req_t      req,
  input  logic [TIME_W-1:0] now,
  input  logic [HOLD_W-1:0] holdoff_ms,
  output logic              allow
);

  logic [TIME_W-1:0] start [NUM_CH];
  logic [NUM_CH-1:0] active;
  logic              expired;

  assign expired = (now - start[req.ch]) > TIME_W'(holdoff_ms);

  always_comb begin
    priority if (req.at_centre) begin
      allow = 1'b1;
    end else if (!active[req.ch]) begin
      allow = 1'b1;
    end else begin
      allow = expired;
    end
  end

  // start needs no reset: it is only read while its active bit is set
  always_ff @(posedge clk) begin
    if (req.check && req.at_centre) begin
      start[req.ch] <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (req.check) begin
      if (req.at_centre) begin
        active[req.ch] <= 1'b1;
      end else if (active[req.ch] && expired) begin
        active[req.ch] <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/akla_step.sv @@
// Detent target: old level moved by unit step times multiplier, snapped to
// the centre on crossing, saturated to the level range. Depends on akla_pkg.
module akla_step
  import akla_pkg::*;
#(
  parameter int LEVEL_BITS = 12
) (
  input  logic [LEVEL_BITS-1:0] old_level,
  input  logic [LEVEL_BITS-1:0] centre,
  input  logic [STEP_W-1:0]     unit_step,
  input  logic [MULT_W-1:0]     mult,
  input  logic                  dir,
  output logic [LEVEL_BITS-1:0] target
);

  // headroom for the largest move either way
  localparam int SW = LEVEL_BITS + 4;
  localparam int PROD_W = STEP_W + MULT_W;
  localparam logic signed [SW-1:0] LEVEL_MAX_S = SW'((1 << LEVEL_BITS) - 1);

  logic [PROD_W-1:0]   delta;
  logic signed [SW-1:0] old_s;
  logic signed [SW-1:0] centre_s;
  logic signed [SW-1:0] moved;
  logic signed [SW-1:0] snapped;

  assign delta    = PROD_W'(unit_step) * PROD_W'(mult);
  assign old_s    = $signed(SW'(old_level));
  assign centre_s = $signed(SW'(centre));
  assign moved    = dir ? old_s + $signed(SW'(delta)) : old_s - $signed(SW'(delta));

  always_comb begin
    if ((old_s > centre_s && moved < centre_s) || (old_s < centre_s && moved > centre_s)) begin
      snapped = centre_s;
    end else begin
      snapped = moved;
    end
    priority if (snapped < 0) begin
      target = '0;
    end else if (snapped > LEVEL_MAX_S) begin
      target = LEVEL_MAX_S[LEVEL_BITS-1:0];
    end else begin
      target = snapped[LEVEL_BITS-1:0];
    end
  end

endmodule

@@ hdl/accelerated_knob_level_adjuster_core.sv @@
// Accelerated knob level adjuster, top level. Depends on akla_pkg, akla_if,
// akla_accel, akla_holdoff and akla_step.
//
// Usage:
//   items   : valid/ready channel of input words (action, knob, direction).
//             Ticks advance the millisecond clock, detents move a knob level
//             with acceleration, recentre sets the level to the centre.
//   results : one word per input word (knob_id, level, applied, multiplier).
//   cfg_we / cfg_index / cfg_data : register writes, taken at any clock edge
//             with cfg_we high; write only while no words are in flight.
// Path: an accepted word is captured in the input register, and its result is
// registered in the result register once results is not held off.
// Throughput: one word per cycle while results is not held off. All state
// (time, timestamps, hold-offs, levels) is read and updated in the logic
// between the input and result registers, so each word sees the previous word.
// Stall: when results is held off, the result register keeps its word and
// the input register still takes one more word; items.ready drops only when
// both are full.
// Reset (synchronous, rst high): time and timestamps cleared, hold-offs
// cleared, all levels set to the clamped reset centre, registers to reset.
module accelerated_knob_level_adjuster_core
  import akla_pkg::*;
#(
  parameter int LEVEL_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  akla_in_if.sink              items,
  akla_out_if.source           results,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NUM_LEVELS = 5;
  localparam int LIDX_W = 3;
  localparam int LEVEL_MAX_I = (1 << LEVEL_BITS) - 1;
  localparam int CENTRE_RESET_I = int'(CENTRE_RESET);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'(LEVEL_MAX_I);
  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET =
    LEVEL_BITS'((CENTRE_RESET_I > LEVEL_MAX_I) ? LEVEL_MAX_I : CENTRE_RESET_I);
  localparam int CMP_W = 17;

  // configuration registers
  logic [CENTRE_W-1:0] centre_level;
  logic [STEP_W-1:0]   unit_step;
  logic [SRC_W-1:0]    trigger_source;
  logic [HOLD_W-1:0]   holdoff_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_level   <= CENTRE_RESET;
      unit_step      <= STEP_RESET;
      trigger_source <= SOURCE_RESET;
      holdoff_ms     <= HOLDOFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTRE:  centre_level   <= cfg_data[CENTRE_W-1:0];
        REG_STEP:    unit_step      <= cfg_data[STEP_W-1:0];
        REG_SOURCE:  trigger_source <= cfg_data[SRC_W-1:0];
        REG_HOLDOFF: holdoff_ms     <= cfg_data[HOLD_W-1:0];
      endcase
    end
  end

  // input register
  logic                s1_valid;
  logic [ACTION_W-1:0] s1_action;
  logic [KNOB_W-1:0]   s1_knob;
  logic                s1_dir;
  logic                advance;
  logic                fire;

  assign advance     = !results.valid || results.ready;
  assign fire        = s1_valid && advance;
  assign items.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      s1_action <= items.action;
      s1_knob   <= items.knob;
      s1_dir    <= items.direction;
    end
  end

  // decode
  logic                  knob_ok;
  logic [CH_W-1:0]       src_ch;
  logic [CH_W-1:0]       ch;
  logic [LIDX_W-1:0]     lvl_idx;
  logic                  is_detent;
  logic                  is_recentre;
  logic [LEVEL_BITS-1:0] centre;

  assign knob_ok     = s1_knob != KNOB_NONE;
  assign src_ch      = (trigger_source > SRC_EXT) ? SRC_EXT : trigger_source;
  assign ch          = (s1_knob == KNOB_TRIG) ? src_ch : s1_knob;
  assign lvl_idx     = (s1_knob == KNOB_TRIG) ? LIDX_W'(2) + LIDX_W'(src_ch)
                                              : LIDX_W'(s1_knob);
  assign is_detent   = (s1_action == ACT_DETENT) && knob_ok;
  assign is_recentre = (s1_action == ACT_RECENTRE) && knob_ok;
  assign centre      = (CMP_W'(centre_level) > CMP_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                                : LEVEL_BITS'(centre_level);

  // timing and acceleration
  logic [TIME_W-1:0] now;
  logic [MULT_W-1:0] mult;

  akla_accel u_accel (
    .clk  (clk),
    .rst  (rst),
    .tick (fire && (s1_action == ACT_TICK)),
    .take (fire && is_detent),
    .slot ({s1_knob, s1_dir}),
    .now  (now),
    .mult (mult)
  );

  // level bank
  logic [LEVEL_BITS-1:0] levels [NUM_LEVELS];
  logic [LEVEL_BITS-1:0] old_level;
  logic [LEVEL_BITS-1:0] target;

  assign old_level = levels[lvl_idx];

  akla_step #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_step (
    .old_level (old_level),
    .centre    (centre),
    .unit_step (unit_step),
    .mult      (mult),
    .dir       (s1_dir),
    .target    (target)
  );

  holdoff_req_t hreq;
  logic         allow;

  assign hreq.check     = fire && is_detent;
  assign hreq.ch        = ch;
  assign hreq.at_centre = target == centre;

  akla_holdoff u_holdoff (
    .clk        (clk),
    .rst        (rst),
    .req        (hreq),
    .now        (now),
    .holdoff_ms (holdoff_ms),
    .allow      (allow)
  );

  logic                  move_ok;
  logic                  applied;
  logic [LEVEL_BITS-1:0] new_level;

  assign move_ok = is_detent && allow;
  assign applied = move_ok || is_recentre;

  always_comb begin
    priority if (move_ok) begin
      new_level = target;
    end else if (is_recentre) begin
      new_level = centre;
    end else begin
      new_level = old_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        levels[i] <= LEVEL_RESET;
      end
    end else if (fire && applied) begin
      levels[lvl_idx] <= new_level;
    end
  end

  // result register
  logic                  r_valid;
  logic [KNOB_W-1:0]     r_knob;
  logic [LEVEL_BITS-1:0] r_level;
  logic                  r_applied;
  logic [MULT_W-1:0]     r_mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      r_knob    <= s1_knob;
      r_level   <= knob_ok ? new_level : '0;
      r_applied <= applied;
      r_mult    <= is_detent ? mult : MULT_1;
    end
  end

  assign results.valid      = r_valid;
  assign results.knob_id    = r_knob;
  assign results.level      = r_level;
  assign results.applied    = r_applied;
  assign results.multiplier = r_mult;

endmodule
